### design/irim_pkg.sv
// Shared types, constants and codes of the image rotation block.
`timescale 1ns / 1ps

package irim_pkg;

   // Frame store geometry.
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int COORD_LIMIT = 512;
   localparam int WIDTH_LIMIT  = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
   localparam int HEIGHT_LIMIT = (MAX_HEIGHT < COORD_LIMIT) ? MAX_HEIGHT : COORD_LIMIT;
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // Field widths.
   localparam int COORD_W = 9;
   localparam int PIXEL_W = 8;
   localparam int TRIG_W  = 16;
   localparam int SIZE_W  = 10;

   // Datapath widths of the rotation.
   localparam int FRAC_BITS = 14;
   localparam int TX_W      = COORD_W + 1;
   localparam int TRIGX_W   = TRIG_W + 1;
   localparam int PROD_W    = TX_W + TRIGX_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int Q_W       = SUM_W - FRAC_BITS;
   localparam int NX_W      = Q_W + 1;

   localparam logic [PIXEL_W-1:0] WHITE = 8'hff;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request type codes on the input channel.
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_FETCH = 2'd1;
   localparam logic [1:0] REQ_COORD = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COSINE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGINX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGINY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT  = 3'd5;

   // Operation that the back part carries out.
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_FETCH,
      OP_COORD
   } irim_op_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [PIXEL_W-1:0] pixel_in;
   } irim_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic [COORD_W-1:0] result_x;
      logic [COORD_W-1:0] result_y;
      logic               in_frame;
   } irim_rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sine_value;
      logic signed [TRIG_W-1:0] cosine_value;
      logic [COORD_W-1:0]       origin_x;
      logic [COORD_W-1:0]       origin_y;
      logic [SIZE_W-1:0]        frame_width;
      logic [SIZE_W-1:0]        frame_height;
   } irim_cfg_type;

   typedef struct packed {
      irim_op_type        op;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [PIXEL_W-1:0] pixel_in;
   } irim_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } irim_qstat_type;

endpackage

### design/irim_front.sv
// Front part: accepts requests and classifies them into queue items.
`timescale 1ns / 1ps

module irim_front (
   input  logic                     start,
   output logic                     busy,
   input  irim_pkg::irim_req_type   req_data,
   input  irim_pkg::irim_qstat_type qstat,
   output logic                     push,
   output irim_pkg::irim_item_type  item
);

   logic accept;
   logic keep;

   // A request is taken whenever the queue has room.
   assign busy   = qstat.full;
   assign accept = start && !qstat.full;

   // Decode the request type; unused codes and loads outside the store are dropped.
   always_comb begin
      item.coord_x  = req_data.coord_x;
      item.coord_y  = req_data.coord_y;
      item.pixel_in = req_data.pixel_in;
      case (req_data.req_type)
         irim_pkg::REQ_LOAD: begin
            item.op = irim_pkg::OP_LOAD;
            keep    = (32'(req_data.coord_x) < irim_pkg::MAX_WIDTH) &&
                      (32'(req_data.coord_y) < irim_pkg::MAX_HEIGHT);
         end
         irim_pkg::REQ_FETCH: begin
            item.op = irim_pkg::OP_FETCH;
            keep    = 1'b1;
         end
         irim_pkg::REQ_COORD: begin
            item.op = irim_pkg::OP_COORD;
            keep    = 1'b1;
         end
         default: begin
            item.op = irim_pkg::OP_LOAD;
            keep    = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;

endmodule

### design/irim_queue.sv
// Short first-in first-out queue that decouples the front and back parts.
`timescale 1ns / 1ps

module irim_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  irim_pkg::irim_item_type  item_in,
   input  logic                     pop,
   output irim_pkg::irim_item_type  item_out,
   output irim_pkg::irim_qstat_type stat
);

   irim_pkg::irim_item_type              entry_ff [irim_pkg::QUEUE_DEPTH];
   logic [irim_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [irim_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [irim_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                 push_ok;
   logic                                 pop_ok;

   assign stat.full  = (count_ff == irim_pkg::QUEUE_CNT_W'(irim_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign push_ok    = push && !stat.full;
   assign pop_ok     = pop && !stat.empty;
   assign item_out   = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == irim_pkg::QUEUE_PTR_W'(irim_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == irim_pkg::QUEUE_PTR_W'(irim_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   // The front part never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < irim_pkg::QUEUE_CNT_W'(irim_pkg::QUEUE_DEPTH)))
      else $error("Queue push while full.");

   // An empty queue has its pointers together.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Queue pointers disagree with an empty count.");

endmodule

### design/irim_back.sv
// Back part: rotation pipeline, frame memory and result register.
`timescale 1ns / 1ps

module irim_back (
   input  logic                     clock,
   input  logic                     reset,
   input  irim_pkg::irim_cfg_type   cfg,
   input  irim_pkg::irim_qstat_type qstat,
   input  irim_pkg::irim_item_type  item,
   output logic                     pop,
   output logic                     rsp_valid,
   output irim_pkg::irim_rsp_type   rsp_data
);

   // Round a Q14 value to an integer, halves away from zero.
   function automatic logic signed [irim_pkg::Q_W-1:0] round_q14(
      input logic signed [irim_pkg::SUM_W-1:0] v
   );
      logic [irim_pkg::SUM_W-1:0] mag;
      logic [irim_pkg::SUM_W-1:0] sh;
      mag = v[irim_pkg::SUM_W-1] ? irim_pkg::SUM_W'(-v) : irim_pkg::SUM_W'(v);
      sh  = (mag + irim_pkg::SUM_W'(1 << (irim_pkg::FRAC_BITS - 1))) >> irim_pkg::FRAC_BITS;
      round_q14 = v[irim_pkg::SUM_W-1] ? -$signed(sh[irim_pkg::Q_W-1:0]) :
                                         $signed(sh[irim_pkg::Q_W-1:0]);
   endfunction

   localparam logic [irim_pkg::SIZE_W-1:0] W_LIM = irim_pkg::SIZE_W'(irim_pkg::WIDTH_LIMIT);
   localparam logic [irim_pkg::SIZE_W-1:0] H_LIM = irim_pkg::SIZE_W'(irim_pkg::HEIGHT_LIMIT);

   // Stage 0: translated coordinate and signed trig values.
   logic                                  s0_vld_ff, s0_vld_in;
   irim_pkg::irim_item_type               s0_item_ff;
   logic signed [irim_pkg::TX_W-1:0]      s0_tx_ff, s0_tx_in;
   logic signed [irim_pkg::TX_W-1:0]      s0_ty_ff, s0_ty_in;
   logic signed [irim_pkg::TRIGX_W-1:0]   s0_s_ff, s0_s_in;
   logic signed [irim_pkg::TRIGX_W-1:0]   s0_c_ff, s0_c_in;
   // Stage 1: four partial products.
   logic                                  s1_vld_ff;
   irim_pkg::irim_item_type               s1_item_ff;
   logic signed [irim_pkg::PROD_W-1:0]    s1_xc_ff, s1_xc_in;
   logic signed [irim_pkg::PROD_W-1:0]    s1_ys_ff, s1_ys_in;
   logic signed [irim_pkg::PROD_W-1:0]    s1_yc_ff, s1_yc_in;
   logic signed [irim_pkg::PROD_W-1:0]    s1_xs_ff, s1_xs_in;
   // Stage 2: rotated sums.
   logic                                  s2_vld_ff;
   irim_pkg::irim_item_type               s2_item_ff;
   logic signed [irim_pkg::SUM_W-1:0]     s2_a_ff, s2_a_in;
   logic signed [irim_pkg::SUM_W-1:0]     s2_b_ff, s2_b_in;
   // Stage 3: rounded source point, bounds check and memory address.
   logic                                  s3_vld_ff;
   irim_pkg::irim_op_type                 s3_op_ff;
   logic [irim_pkg::ADDR_W-1:0]           s3_addr_ff, s3_addr_in;
   logic                                  s3_inside_ff, s3_inside_in;
   logic [irim_pkg::COORD_W-1:0]          s3_rx_ff, s3_rx_in;
   logic [irim_pkg::COORD_W-1:0]          s3_ry_ff, s3_ry_in;
   logic [irim_pkg::PIXEL_W-1:0]          s3_pix_ff;
   logic signed [irim_pkg::NX_W-1:0]      nx, ny;
   logic [irim_pkg::SIZE_W-1:0]           lim_w, lim_h;
   // Stage 4: memory access.
   logic [irim_pkg::PIXEL_W-1:0]          frame_mem_ff [irim_pkg::MAX_WIDTH * irim_pkg::MAX_HEIGHT];
   logic [irim_pkg::PIXEL_W-1:0]          rd_data_ff;
   logic                                  s4_vld_ff, s4_vld_in;
   irim_pkg::irim_op_type                 s4_op_ff;
   logic                                  s4_inside_ff;
   logic [irim_pkg::COORD_W-1:0]          s4_rx_ff, s4_ry_ff;
   // Result register.
   logic                                  rsp_valid_ff;
   irim_pkg::irim_rsp_type                rsp_ff, rsp_in;

   // The pipeline never stalls, so the head of the queue is taken at once.
   assign pop = !qstat.empty;

   // Stage 0: move the origin to zero and negate the sine for a forward rotation.
   always_comb begin
      s0_vld_in = !qstat.empty;
      s0_tx_in  = $signed({1'b0, item.coord_x}) - $signed({1'b0, cfg.origin_x});
      s0_ty_in  = $signed({1'b0, item.coord_y}) - $signed({1'b0, cfg.origin_y});
      s0_c_in   = irim_pkg::TRIGX_W'(cfg.cosine_value);
      s0_s_in   = (item.op == irim_pkg::OP_COORD) ? -irim_pkg::TRIGX_W'(cfg.sine_value) :
                                                    irim_pkg::TRIGX_W'(cfg.sine_value);
   end

   // Stage 1: partial products, with both operands widened to the product width.
   always_comb begin
      s1_xc_in = irim_pkg::PROD_W'(s0_tx_ff) * irim_pkg::PROD_W'(s0_c_ff);
      s1_ys_in = irim_pkg::PROD_W'(s0_ty_ff) * irim_pkg::PROD_W'(s0_s_ff);
      s1_yc_in = irim_pkg::PROD_W'(s0_ty_ff) * irim_pkg::PROD_W'(s0_c_ff);
      s1_xs_in = irim_pkg::PROD_W'(s0_tx_ff) * irim_pkg::PROD_W'(s0_s_ff);
   end

   // Stage 2: rotation sums.
   always_comb begin
      s2_a_in = irim_pkg::SUM_W'(s1_xc_ff) + irim_pkg::SUM_W'(s1_ys_ff);
      s2_b_in = irim_pkg::SUM_W'(s1_yc_ff) - irim_pkg::SUM_W'(s1_xs_ff);
   end

   // Stage 3: round, add the origin back, check the frame and form the address.
   always_comb begin
      nx = irim_pkg::NX_W'(round_q14(s2_a_ff)) + irim_pkg::NX_W'($signed({1'b0, cfg.origin_x}));
      ny = irim_pkg::NX_W'(round_q14(s2_b_ff)) + irim_pkg::NX_W'($signed({1'b0, cfg.origin_y}));
      lim_w = (cfg.frame_width < W_LIM) ? cfg.frame_width : W_LIM;
      lim_h = (cfg.frame_height < H_LIM) ? cfg.frame_height : H_LIM;
      s3_inside_in = !nx[irim_pkg::NX_W-1] && !ny[irim_pkg::NX_W-1] &&
                     (nx[irim_pkg::NX_W-2:0] < (irim_pkg::NX_W-1)'(lim_w)) &&
                     (ny[irim_pkg::NX_W-2:0] < (irim_pkg::NX_W-1)'(lim_h));
      s3_rx_in = s3_inside_in ? nx[irim_pkg::COORD_W-1:0] : s2_item_ff.coord_x;
      s3_ry_in = s3_inside_in ? ny[irim_pkg::COORD_W-1:0] : s2_item_ff.coord_y;
      if (s2_item_ff.op == irim_pkg::OP_LOAD) begin
         s3_addr_in = irim_pkg::ADDR_W'(s2_item_ff.coord_y) *
                      irim_pkg::ADDR_W'(irim_pkg::MAX_WIDTH) +
                      irim_pkg::ADDR_W'(s2_item_ff.coord_x);
      end else begin
         s3_addr_in = irim_pkg::ADDR_W'(ny[irim_pkg::COORD_W-1:0]) *
                      irim_pkg::ADDR_W'(irim_pkg::MAX_WIDTH) +
                      irim_pkg::ADDR_W'(nx[irim_pkg::COORD_W-1:0]);
      end
   end

   // Only fetch and coordinate transactions leave the memory stage.
   assign s4_vld_in = s3_vld_ff && (s3_op_ff != irim_pkg::OP_LOAD);

   // Result formatting: white for a fetch out of frame, zero pixel for coordinates.
   always_comb begin
      rsp_in.result_x = s4_rx_ff;
      rsp_in.result_y = s4_ry_ff;
      rsp_in.in_frame = s4_inside_ff;
      if (s4_op_ff == irim_pkg::OP_FETCH) begin
         rsp_in.pixel_out = s4_inside_ff ? rd_data_ff : irim_pkg::WHITE;
      end else begin
         rsp_in.pixel_out = '0;
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_vld_ff    <= s0_vld_in;
         s1_vld_ff    <= s0_vld_ff;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s4_vld_in;
         rsp_valid_ff <= s4_vld_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      s0_item_ff   <= item;
      s0_tx_ff     <= s0_tx_in;
      s0_ty_ff     <= s0_ty_in;
      s0_s_ff      <= s0_s_in;
      s0_c_ff      <= s0_c_in;
      s1_item_ff   <= s0_item_ff;
      s1_xc_ff     <= s1_xc_in;
      s1_ys_ff     <= s1_ys_in;
      s1_yc_ff     <= s1_yc_in;
      s1_xs_ff     <= s1_xs_in;
      s2_item_ff   <= s1_item_ff;
      s2_a_ff      <= s2_a_in;
      s2_b_ff      <= s2_b_in;
      s3_op_ff     <= s2_item_ff.op;
      s3_addr_ff   <= s3_addr_in;
      s3_inside_ff <= s3_inside_in;
      s3_rx_ff     <= s3_rx_in;
      s3_ry_ff     <= s3_ry_in;
      s3_pix_ff    <= s2_item_ff.pixel_in;
      s4_op_ff     <= s3_op_ff;
      s4_inside_ff <= s3_inside_ff;
      s4_rx_ff     <= s3_rx_ff;
      s4_ry_ff     <= s3_ry_ff;
      rsp_ff       <= rsp_in;
   end

   // Frame memory: one write or one registered read per cycle, in order.
   always_ff @(posedge clock) begin
      if (s3_vld_ff && (s3_op_ff == irim_pkg::OP_LOAD)) begin
         frame_mem_ff[s3_addr_ff] <= s3_pix_ff;
      end
      rd_data_ff <= frame_mem_ff[s3_addr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every fetch or coordinate transaction in stage 0 gives its result after stages 1 to 4 and the result register.
   assert property (@(posedge clock) disable iff (reset)
      (s0_vld_ff && (s0_item_ff.op != irim_pkg::OP_LOAD)) |-> ##5 rsp_valid_ff)
      else $error("Result missing after a fetch or coordinate transaction.");

   // No result appears without such a transaction behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(s0_vld_ff && (s0_item_ff.op != irim_pkg::OP_LOAD), 5))
      else $error("Result strobe without a matching transaction.");

endmodule

### design/image_rotation_inverse_map.sv
// Top level of the nearest-neighbor image rotation block.
`timescale 1ns / 1ps

// A request is taken at a clock edge with start high and busy low; loads write one
// pixel, fetches and coordinate requests each give one result after the queue and
// back stages, shown with rsp_valid for exactly one cycle, and the receiver cannot
// stall. One request is taken every cycle: the back pipeline never stops, the frame
// memory does one write or one read per cycle in its memory stage, and busy rises
// only if the four-entry queue in front of the pipeline fills. Pixels that were never
// loaded read as undefined; there is no clearing pass after reset. Configuration
// writes are taken every cycle and must only be made while no transaction is in flight.
module image_rotation_inverse_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  irim_pkg::irim_req_type              req_data,
   output logic                                rsp_valid,
   output irim_pkg::irim_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irim_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irim_pkg::CSR_DATA_W-1:0]     csr_data
);

   irim_pkg::irim_cfg_type   cfg_ff, cfg_in;
   irim_pkg::irim_qstat_type qstat;
   irim_pkg::irim_item_type  push_item;
   irim_pkg::irim_item_type  head_item;
   logic                     push;
   logic                     pop;

   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            irim_pkg::CSR_SINE:    cfg_in.sine_value   = csr_data;
            irim_pkg::CSR_COSINE:  cfg_in.cosine_value = csr_data;
            irim_pkg::CSR_ORIGINX: cfg_in.origin_x     = csr_data[irim_pkg::COORD_W-1:0];
            irim_pkg::CSR_ORIGINY: cfg_in.origin_y     = csr_data[irim_pkg::COORD_W-1:0];
            irim_pkg::CSR_WIDTH:   cfg_in.frame_width  = csr_data[irim_pkg::SIZE_W-1:0];
            irim_pkg::CSR_HEIGHT:  cfg_in.frame_height = csr_data[irim_pkg::SIZE_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sine_value   <= '0;
         cfg_ff.cosine_value <= 16'sd16384;
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.frame_width  <= 10'd512;
         cfg_ff.frame_height <= 10'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   irim_front u_front (
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .qstat    (qstat),
      .push     (push),
      .item     (push_item)
   );

   irim_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (push_item),
      .pop      (pop),
      .item_out (head_item),
      .stat     (qstat)
   );

   irim_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .item      (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/tb_image_rotation_inverse_map.sv
// Self-checking testbench for the nearest-neighbor image rotation block.
`timescale 1ns / 1ps

module tb_image_rotation_inverse_map;

   // Request code that the block must ignore, and a register index that holds nothing.
   localparam logic [1:0]                       REQ_UNUSED = 2'd3;
   localparam logic [irim_pkg::CSR_INDEX_W-1:0] CSR_SPARE  = 3'd7;

   localparam int STORE_DEPTH    = irim_pkg::MAX_WIDTH * irim_pkg::MAX_HEIGHT;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 185;
   localparam int PRINT_LIMIT    = 50;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   irim_pkg::irim_req_type             req_data = '0;
   logic                               rsp_valid;
   irim_pkg::irim_rsp_type             rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [irim_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [irim_pkg::CSR_DATA_W-1:0]    csr_data = '0;

   // Register values as the block should hold them; written only while it is idle.
   irim_pkg::irim_cfg_type             cfg_shadow = '{sine_value: 16'sd0,
                                                      cosine_value: 16'sd16384,
                                                      origin_x: '0, origin_y: '0,
                                                      frame_width: 10'd512,
                                                      frame_height: 10'd512};

   // Frame contents as loaded by accepted transactions, and which pixels the
   // stimulus has already queued a load for.
   logic [irim_pkg::PIXEL_W-1:0]       pixel_mirror [0:STORE_DEPTH-1];
   bit                                 loaded_mask  [0:STORE_DEPTH-1];

   irim_pkg::irim_req_type             req_backlog[$];
   irim_pkg::irim_rsp_type             rsp_expected[$];

   bit                                 steady_phase = 1'b0;
   int                                 gap_left = 0;
   int                                 idle_cycles = 0;
   int                                 error_count = 0;
   int                                 n_load = 0, n_fetch = 0, n_coord = 0, n_ignored = 0;
   int                                 n_checked = 0, n_inside = 0, n_white = 0;
   int                                 n_csr = 0, n_settings = 1;

   irim_pkg::irim_rsp_type             rsp_want;
   logic                               took;
   logic                               next_start;

   image_rotation_inverse_map i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int store_index(input logic [irim_pkg::COORD_W-1:0] x,
                                      input logic [irim_pkg::COORD_W-1:0] y);
      return int'(y) * irim_pkg::MAX_WIDTH + int'(x);
   endfunction

   // Divide by 2^14, rounding half away from zero.
   function automatic longint round_q14(input longint v);
      if (v >= 0) begin
         return (v + (longint'(1) << (irim_pkg::FRAC_BITS - 1))) >>> irim_pkg::FRAC_BITS;
      end
      return -((-v + (longint'(1) << (irim_pkg::FRAC_BITS - 1))) >>> irim_pkg::FRAC_BITS);
   endfunction

   // Maps a point through the rotation under the current registers. Returns 1
   // when the mapped point lies inside the frame in use.
   function automatic logic map_coord(input logic [1:0] kind,
                                      input logic [irim_pkg::COORD_W-1:0] x,
                                      input logic [irim_pkg::COORD_W-1:0] y,
                                      output logic [irim_pkg::COORD_W-1:0] nx_o,
                                      output logic [irim_pkg::COORD_W-1:0] ny_o);
      longint sn, cs, ox, oy, tx, ty, nx, ny, w, h;
      sn = $signed(cfg_shadow.sine_value);
      cs = $signed(cfg_shadow.cosine_value);
      if (kind == irim_pkg::REQ_COORD) begin
         sn = -sn;
      end
      ox = cfg_shadow.origin_x;
      oy = cfg_shadow.origin_y;
      tx = longint'(x) - ox;
      ty = longint'(y) - oy;
      nx = round_q14(tx * cs + ty * sn) + ox;
      ny = round_q14(ty * cs - tx * sn) + oy;
      w = (cfg_shadow.frame_width > irim_pkg::WIDTH_LIMIT) ?
          irim_pkg::WIDTH_LIMIT : cfg_shadow.frame_width;
      h = (cfg_shadow.frame_height > irim_pkg::HEIGHT_LIMIT) ?
          irim_pkg::HEIGHT_LIMIT : cfg_shadow.frame_height;
      nx_o = nx[irim_pkg::COORD_W-1:0];
      ny_o = ny[irim_pkg::COORD_W-1:0];
      return (nx >= 0) && (ny >= 0) && (nx < w) && (ny < h);
   endfunction

   // Result that a fetch or coordinate transaction must produce.
   function automatic irim_pkg::irim_rsp_type predict_rotation(input irim_pkg::irim_req_type r);
      irim_pkg::irim_rsp_type p;
      logic [irim_pkg::COORD_W-1:0] sx, sy;
      logic hit;
      hit = map_coord(r.req_type, r.coord_x, r.coord_y, sx, sy);
      p.in_frame = hit;
      p.result_x = hit ? sx : r.coord_x;
      p.result_y = hit ? sy : r.coord_y;
      if (r.req_type == irim_pkg::REQ_FETCH) begin
         p.pixel_out = hit ? pixel_mirror[store_index(sx, sy)] : irim_pkg::WHITE;
      end else begin
         p.pixel_out = '0;
      end
      return p;
   endfunction

   // Idle cycles after a request: mostly none or short, a few long.
   function automatic int draw_gap();
      int r;
      if (steady_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Queues one request. A fetch whose source pixel was never loaded gets a load
   // of that pixel queued in front of it, so no undefined pixel is ever read.
   task automatic queue_item(input logic [1:0] kind,
                             input logic [irim_pkg::COORD_W-1:0] x,
                             input logic [irim_pkg::COORD_W-1:0] y,
                             input logic [irim_pkg::PIXEL_W-1:0] pix);
      irim_pkg::irim_req_type item;
      logic [irim_pkg::COORD_W-1:0] sx, sy;
      if (kind == irim_pkg::REQ_FETCH && map_coord(kind, x, y, sx, sy)
          && !loaded_mask[store_index(sx, sy)]) begin
         item = '{req_type: irim_pkg::REQ_LOAD, coord_x: sx, coord_y: sy,
                  pixel_in: irim_pkg::PIXEL_W'($urandom)};
         loaded_mask[store_index(sx, sy)] = 1'b1;
         req_backlog.insert(req_backlog.size(), item);
      end
      if (kind == irim_pkg::REQ_LOAD) begin
         loaded_mask[store_index(x, y)] = 1'b1;
      end
      item = '{req_type: kind, coord_x: x, coord_y: y, pixel_in: pix};
      req_backlog.insert(req_backlog.size(), item);
   endtask

   // One register write; called at a clock edge, returns at the edge that takes it.
   // The caller lowers csr_valid after the last write of a group.
   task automatic write_csr(input logic [irim_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [irim_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         irim_pkg::CSR_SINE:    cfg_shadow.sine_value   = value;
         irim_pkg::CSR_COSINE:  cfg_shadow.cosine_value = value;
         irim_pkg::CSR_ORIGINX: cfg_shadow.origin_x     = value[irim_pkg::COORD_W-1:0];
         irim_pkg::CSR_ORIGINY: cfg_shadow.origin_y     = value[irim_pkg::COORD_W-1:0];
         irim_pkg::CSR_WIDTH:   cfg_shadow.frame_width  = value[irim_pkg::SIZE_W-1:0];
         irim_pkg::CSR_HEIGHT:  cfg_shadow.frame_height = value[irim_pkg::SIZE_W-1:0];
         default: ;
      endcase
      n_csr++;
   endtask

   // Waits until every queued transaction is in and every result is back, then
   // lets the pipeline drain of loads that give no result.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || start || rsp_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [irim_pkg::CSR_DATA_W-1:0] pick_trig();
      logic [irim_pkg::CSR_DATA_W-1:0] v;
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         case ($urandom_range(0, 2))
            0: v = 16'sd16384;
            1: v = -16'sd16384;
            default: v = '0;
         endcase
      end else if (r < 7) begin
         v = irim_pkg::CSR_DATA_W'($urandom_range(0, 32768)) - 16'd16384;
      end else if (r < 9) begin
         case ($urandom_range(0, 3))
            0: v = 16'h7fff;
            1: v = 16'h8000;
            2: v = 16'hc000;
            default: v = 16'h4000;
         endcase
      end else begin
         v = irim_pkg::CSR_DATA_W'($urandom);
      end
      return v;
   endfunction

   // Origin value, sometimes with junk above the register's width.
   function automatic logic [irim_pkg::CSR_DATA_W-1:0] pick_origin();
      logic [irim_pkg::CSR_DATA_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = 16'd511;
         default: v = irim_pkg::CSR_DATA_W'($urandom_range(0, 511));
      endcase
      if ($urandom_range(0, 3) == 0) begin
         v[irim_pkg::CSR_DATA_W-1:irim_pkg::COORD_W] = 7'($urandom);
      end
      return v;
   endfunction

   function automatic logic [irim_pkg::CSR_DATA_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         return '0;
      end else if (r < 12) begin
         return 16'd1;
      end else if (r < 27) begin
         return 16'd512;
      end else if (r < 37) begin
         return irim_pkg::CSR_DATA_W'($urandom_range(513, 1023));
      end
      return irim_pkg::CSR_DATA_W'($urandom_range(2, 511));
   endfunction

   // Coordinate, mostly inside the frame in use.
   function automatic logic [irim_pkg::COORD_W-1:0] pick_coord(
      input logic [irim_pkg::SIZE_W-1:0] size
   );
      int lim;
      lim = (size > 512) ? 512 : int'(size);
      if (lim > 0 && $urandom_range(0, 99) < 70) begin
         return irim_pkg::COORD_W'($urandom_range(0, lim - 1));
      end
      return irim_pkg::COORD_W'($urandom_range(0, 511));
   endfunction

   // Driver: presents queued requests, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         took = start && !busy;
         next_start = start;
         if (took) begin
            case (req_data.req_type)
               irim_pkg::REQ_LOAD: begin
                  pixel_mirror[store_index(req_data.coord_x, req_data.coord_y)] =
                     req_data.pixel_in;
                  n_load++;
               end
               irim_pkg::REQ_FETCH, irim_pkg::REQ_COORD: begin
                  rsp_expected.insert(rsp_expected.size(), predict_rotation(req_data));
                  if (req_data.req_type == irim_pkg::REQ_FETCH) begin
                     n_fetch++;
                  end else begin
                     n_coord++;
                  end
               end
               default: n_ignored++;
            endcase
         end
         if (start && busy) begin
            next_start = 1'b1;
         end else if (gap_left > 0) begin
            next_start = 1'b0;
            gap_left--;
         end else if (req_backlog.size() != 0) begin
            req_data <= req_backlog.pop_front();
            next_start = 1'b1;
            gap_left = draw_gap();
         end else begin
            next_start = 1'b0;
         end
         start <= next_start;
      end
   end

   // Monitor: every result strobe is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %p", rsp_data));
         end else begin
            rsp_want = rsp_expected.pop_front();
            n_checked++;
            if (rsp_want.in_frame) begin
               n_inside++;
            end
            if (rsp_want.pixel_out == irim_pkg::WHITE && !rsp_want.in_frame) begin
               n_white++;
            end
            if (rsp_data.pixel_out !== rsp_want.pixel_out) begin
               report_mismatch($sformatf("pixel_out expected %0d, got %0d",
                                         rsp_want.pixel_out, rsp_data.pixel_out));
            end
            if (rsp_data.result_x !== rsp_want.result_x) begin
               report_mismatch($sformatf("result_x expected %0d, got %0d",
                                         rsp_want.result_x, rsp_data.result_x));
            end
            if (rsp_data.result_y !== rsp_want.result_y) begin
               report_mismatch($sformatf("result_y expected %0d, got %0d",
                                         rsp_want.result_y, rsp_data.result_y));
            end
            if (rsp_data.in_frame !== rsp_want.in_frame) begin
               report_mismatch($sformatf("in_frame expected %0d, got %0d",
                                         rsp_want.in_frame, rsp_data.in_frame));
            end
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                  idle_cycles, rsp_expected.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus: directed corners first, then random register settings and traffic.
   initial begin : stimulus
      int kind_roll;
      int phase;
      int count;
      logic [irim_pkg::COORD_W-1:0] x, y;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity rotation after reset: frame corners, and the unused request code.
      queue_item(irim_pkg::REQ_LOAD, 9'd0, 9'd0, 8'h00);
      queue_item(irim_pkg::REQ_LOAD, 9'd511, 9'd511, 8'hff);
      queue_item(irim_pkg::REQ_LOAD, 9'd511, 9'd0, 8'haa);
      queue_item(irim_pkg::REQ_LOAD, 9'd0, 9'd511, 8'h55);
      queue_item(irim_pkg::REQ_FETCH, 9'd0, 9'd0, 8'h00);
      queue_item(irim_pkg::REQ_FETCH, 9'd511, 9'd511, 8'hff);
      queue_item(irim_pkg::REQ_FETCH, 9'd511, 9'd0, 8'h00);
      queue_item(irim_pkg::REQ_FETCH, 9'd0, 9'd511, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd0, 9'd0, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd511, 9'd511, 8'hff);
      queue_item(REQ_UNUSED, 9'd511, 9'd511, 8'hff);
      wait_idle();

      // Quarter turn about the center of the store in a clipped frame; sources off the frame fill white.
      write_csr(irim_pkg::CSR_SINE, 16'sd16384);
      write_csr(irim_pkg::CSR_COSINE, 16'd0);
      write_csr(irim_pkg::CSR_ORIGINX, 16'd256);
      write_csr(irim_pkg::CSR_ORIGINY, 16'd256);
      write_csr(irim_pkg::CSR_WIDTH, 16'd300);
      write_csr(irim_pkg::CSR_HEIGHT, 16'd200);
      write_csr(CSR_SPARE, 16'hffff);
      csr_valid <= 1'b0;
      n_settings++;
      queue_item(irim_pkg::REQ_FETCH, 9'd256, 9'd256, 8'h00);
      queue_item(irim_pkg::REQ_FETCH, 9'd0, 9'd0, 8'h00);
      queue_item(irim_pkg::REQ_FETCH, 9'd299, 9'd199, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd511, 9'd511, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd300, 9'd100, 8'h00);
      wait_idle();

      // Exact halves in both directions check rounding away from zero;
      // a width beyond the store is clipped to it.
      write_csr(irim_pkg::CSR_SINE, 16'sd8192);
      write_csr(irim_pkg::CSR_COSINE, 16'sd8192);
      write_csr(irim_pkg::CSR_ORIGINX, 16'd10);
      write_csr(irim_pkg::CSR_ORIGINY, 16'd10);
      write_csr(irim_pkg::CSR_WIDTH, 16'd1023);
      write_csr(irim_pkg::CSR_HEIGHT, 16'd512);
      csr_valid <= 1'b0;
      n_settings++;
      queue_item(irim_pkg::REQ_FETCH, 9'd11, 9'd10, 8'h00);
      queue_item(irim_pkg::REQ_FETCH, 9'd9, 9'd10, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd11, 9'd10, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd10, 9'd9, 8'h00);
      wait_idle();

      // Most negative sine, largest cosine and an empty frame: nothing is inside.
      write_csr(irim_pkg::CSR_SINE, 16'h8000);
      write_csr(irim_pkg::CSR_COSINE, 16'h7fff);
      write_csr(irim_pkg::CSR_WIDTH, 16'd0);
      write_csr(irim_pkg::CSR_HEIGHT, 16'd1);
      csr_valid <= 1'b0;
      n_settings++;
      queue_item(irim_pkg::REQ_FETCH, 9'd5, 9'd5, 8'h00);
      queue_item(irim_pkg::REQ_COORD, 9'd5, 9'd5, 8'h00);
      wait_idle();

      // Random settings, each followed by a burst of mixed traffic.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_csr(irim_pkg::CSR_SINE, pick_trig());
         write_csr(irim_pkg::CSR_COSINE, pick_trig());
         write_csr(irim_pkg::CSR_ORIGINX, pick_origin());
         write_csr(irim_pkg::CSR_ORIGINY, pick_origin());
         write_csr(irim_pkg::CSR_WIDTH, pick_size());
         write_csr(irim_pkg::CSR_HEIGHT, pick_size());
         csr_valid <= 1'b0;
         n_settings++;
         steady_phase = (phase % 3 == 2);
         for (count = 0; count < PHASE_ITEMS; count++) begin
            kind_roll = $urandom_range(0, 99);
            x = pick_coord(cfg_shadow.frame_width);
            y = pick_coord(cfg_shadow.frame_height);
            if (kind_roll < 30) begin
               queue_item(irim_pkg::REQ_LOAD, x, y, irim_pkg::PIXEL_W'($urandom));
            end else if (kind_roll < 70) begin
               queue_item(irim_pkg::REQ_FETCH, x, y, irim_pkg::PIXEL_W'($urandom));
            end else if (kind_roll < 94) begin
               queue_item(irim_pkg::REQ_COORD, x, y, irim_pkg::PIXEL_W'($urandom));
            end else begin
               queue_item(REQ_UNUSED, x, y, irim_pkg::PIXEL_W'($urandom));
            end
         end
         wait_idle();
      end

      while (rsp_expected.size() != 0) begin
         rsp_want = rsp_expected.pop_front();
         report_mismatch($sformatf("result never arrived: %p", rsp_want));
      end

      $display("Run covered %0d loads, %0d fetches, %0d coordinate and %0d unused requests",
               n_load, n_fetch, n_coord, n_ignored);
      $display("under %0d register settings (%0d writes); %0d results checked,",
               n_settings, n_csr, n_checked);
      $display("%0d of them in frame and %0d white.", n_inside, n_white);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
design/irim_pkg.sv
design/irim_front.sv
design/irim_queue.sv
design/irim_back.sv
design/image_rotation_inverse_map.sv
dv/tb_image_rotation_inverse_map.sv
